FILE: src/tmd_pkg.sv
// ----------------------------------------------------------------------------
// tmd_pkg
// Shared types and constants for the typed message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package tmd_pkg;

  // Frame lengths and chat header layout
  localparam logic [31:0] LEN_MOVE     = 32'd14;
  localparam logic [31:0] LEN_ACTION   = 32'd6;
  localparam logic [31:0] CHAT_HEADER  = 32'd9;
  localparam logic [31:0] CHAT_LEN_POS = 32'd5;
  localparam logic [31:0] MAX_RESET    = 32'd1048576;

  // Message type codes as they appear in the type byte
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_MOVE   = 2'd1,
    KIND_CHAT   = 2'd2,
    KIND_ACTION = 2'd3
  } kind_t;

  // Per-byte marks
  typedef struct packed {
    logic first_of_frame;
    logic last_of_frame;
    logic skipped;
    logic aborted;
    logic ignored;
  } marks_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] byte_out;
    kind_t      frame_kind;
    marks_t     marks;
  } result_t;

endpackage

`default_nettype wire

FILE: src/tmd_core.sv
// ----------------------------------------------------------------------------
// tmd_core
// Frame tracking state and per-byte classification of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module tmd_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic [7:0]     data_byte,
  input  wire logic [31:0]    max_bytes,
  output tmd_pkg::result_t    result
);
  import tmd_pkg::*;

  logic        closed;
  logic        closed_next;
  kind_t       current_kind;
  kind_t       current_kind_next;
  logic [31:0] bytes_seen;
  logic [31:0] bytes_seen_next;
  logic [31:0] frame_length;
  logic [31:0] frame_length_next;

  logic [31:0] seen_inc;
  logic [31:0] len_acc;
  logic [31:0] fixed_len;
  logic [32:0] chat_total;
  logic [1:0]  lane;
  logic        last;
  logic        abort;

  // Hold state between transactions, advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      closed       <= 1'b0;
      current_kind <= KIND_NONE;
      bytes_seen   <= '0;
      frame_length <= '0;
    end else if (step) begin
      closed       <= closed_next;
      current_kind <= current_kind_next;
      bytes_seen   <= bytes_seen_next;
      frame_length <= frame_length_next;
    end
  end

  // Chat length bytes land little-endian: offset 5 is lane 0, offset 8 lane 3
  assign seen_inc = bytes_seen + 32'd1;
  assign lane     = bytes_seen[1:0] - 2'd1;
  assign fixed_len = (data_byte == 8'(KIND_MOVE)) ? LEN_MOVE : LEN_ACTION;

  always_comb begin
    len_acc = frame_length;
    if (bytes_seen >= CHAT_LEN_POS) begin
      unique case (lane)
        2'd0: len_acc[7:0]   = frame_length[7:0]   | data_byte;
        2'd1: len_acc[15:8]  = frame_length[15:8]  | data_byte;
        2'd2: len_acc[23:16] = frame_length[23:16] | data_byte;
        2'd3: len_acc[31:24] = frame_length[31:24] | data_byte;
      endcase
    end
  end

  assign chat_total = {1'b0, len_acc} + {1'b0, CHAT_HEADER};

  // Classify the byte and work out the next frame state
  always_comb begin
    closed_next       = closed;
    current_kind_next = current_kind;
    bytes_seen_next   = bytes_seen;
    frame_length_next = frame_length;
    last              = 1'b0;
    abort             = 1'b0;
    result            = '0;
    result.byte_out   = data_byte;
    result.frame_kind = KIND_NONE;

    if (closed) begin
      result.marks.ignored = 1'b1;
    end else if (current_kind == KIND_NONE) begin
      if (data_byte >= 8'd1 && data_byte <= 8'd3) begin
        result.frame_kind           = kind_t'(data_byte[1:0]);
        result.marks.first_of_frame = 1'b1;
        current_kind_next           = kind_t'(data_byte[1:0]);
        bytes_seen_next             = 32'd1;
        frame_length_next           = '0;
        if (data_byte != 8'(KIND_CHAT)) begin
          if (fixed_len > max_bytes) begin
            abort = 1'b1;
          end else begin
            frame_length_next = fixed_len;
          end
        end
      end else begin
        result.marks.skipped = 1'b1;
      end
    end else begin
      result.frame_kind = current_kind;
      bytes_seen_next   = seen_inc;
      if (current_kind == KIND_CHAT && bytes_seen < CHAT_HEADER) begin
        frame_length_next = len_acc;
        if (bytes_seen == CHAT_HEADER - 32'd1) begin
          if (chat_total > {1'b0, max_bytes}) begin
            abort = 1'b1;
          end else begin
            frame_length_next = chat_total[31:0];
            last              = (seen_inc >= chat_total[31:0]);
          end
        end
      end else begin
        last = (seen_inc >= frame_length);
      end
      result.marks.last_of_frame = last;
    end

    // Drop the frame state on completion or abort
    if (last || abort) begin
      current_kind_next = KIND_NONE;
      bytes_seen_next   = '0;
      frame_length_next = '0;
    end
    if (abort) begin
      result.marks.aborted = 1'b1;
      closed_next          = 1'b1;
    end
  end

  // Once closed, the block stays closed until reset
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    closed |=> closed) else $error("closed flag dropped without reset");

  a_abort_closes: assert property (@(posedge clk) disable iff (rst)
    step && result.marks.aborted |=> closed)
    else $error("abort did not close the block");

  a_closed_ignores: assert property (@(posedge clk) disable iff (rst)
    closed |-> result.marks.ignored && result.frame_kind == KIND_NONE)
    else $error("byte not ignored while closed");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    step && result.marks.last_of_frame |=> current_kind == KIND_NONE
      && bytes_seen == 32'd0)
    else $error("frame state not cleared after last byte");

endmodule

`default_nettype wire

FILE: src/typed_message_deframer.sv
// ----------------------------------------------------------------------------
// typed_message_deframer
// Cuts a byte stream into typed messages and marks each byte.
// ----------------------------------------------------------------------------
// Every accepted byte yields exactly one result transaction in the next cycle,
// with its type and first/last/skipped/aborted/ignored marks; bytes are never
// held back until a frame completes. The block takes one byte per cycle: the
// frame state update (a 32-bit add and compare, plus one byte merged into the
// chat length) sits between the input handshake and the result register, and
// the input stalls only while a result waits on a stalled output. The frame
// length limit max_message_bytes (reset 1048576) is written over the config
// channel, which is always ready; write it only while the block is idle. After
// an oversize frame the block reports abort and marks every later byte as
// ignored until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_message_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input bytes
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  // Results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       byte_out,
  output logic [1:0]       frame_kind,
  output logic             first_of_frame,
  output logic             last_of_frame,
  output logic             skipped,
  output logic             aborted,
  output logic             ignored,
  // Configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] max_message_bytes
);
  import tmd_pkg::*;

  logic        in_accept;
  logic [31:0] max_bytes;
  result_t     result;
  result_t     result_q;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Hold the frame length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_bytes <= max_message_bytes;
    end
  end

  tmd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (in_accept),
    .data_byte (data_byte),
    .max_bytes (max_bytes),
    .result    (result)
  );

  // Output register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_q <= result;
    end
  end

  assign byte_out       = result_q.byte_out;
  assign frame_kind     = result_q.frame_kind;
  assign first_of_frame = result_q.marks.first_of_frame;
  assign last_of_frame  = result_q.marks.last_of_frame;
  assign skipped        = result_q.marks.skipped;
  assign aborted        = result_q.marks.aborted;
  assign ignored        = result_q.marks.ignored;

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid) else $error("accepted byte produced no result");

  a_abort_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && aborted |-> !last_of_frame && !skipped && !ignored)
    else $error("aborting byte carries conflicting marks");

  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && skipped |-> frame_kind == 2'(KIND_NONE) && !first_of_frame)
    else $error("skipped byte carries frame marks");

endmodule

`default_nettype wire

FILE: bench/deframer_checker.sv
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the deframer's channels, predicts each byte's marks and compares
// them with the results. Config writes update the predicted length limit.
// The failure count and the number of predicted results still due go back
// to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module deframer_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  byte_out,
  input  wire logic [1:0]  frame_kind,
  input  wire logic        first_of_frame,
  input  wire logic        last_of_frame,
  input  wire logic        skipped,
  input  wire logic        aborted,
  input  wire logic        ignored,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [31:0] cfg_max,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmd_pkg::*;

  // Predicted framer state
  logic        link_closed;
  kind_t       open_kind;
  logic [31:0] bytes_in_frame;
  logic [31:0] frame_total;
  logic [31:0] max_bytes;

  result_t marks_due[$];
  int      err_count = 0;
  int      result_index = 0;

  // Return to the between-frames state
  function automatic void drop_frame();
    open_kind      = KIND_NONE;
    bytes_in_frame = '0;
    frame_total    = '0;
  endfunction

  // Work out the marks of one byte and advance the predicted state
  function automatic result_t predict_marks(input logic [7:0] b);
    result_t     r;
    logic [31:0] pos;
    logic [31:0] need;
    logic [32:0] total;
    logic        done;
    r          = '0;
    r.byte_out = b;
    done       = 1'b0;
    if (link_closed) begin
      r.marks.ignored = 1'b1;
    end else if (open_kind == KIND_NONE) begin
      if (b >= 8'd1 && b <= 8'd3) begin
        r.frame_kind           = kind_t'(b[1:0]);
        r.marks.first_of_frame = 1'b1;
        open_kind              = kind_t'(b[1:0]);
        bytes_in_frame         = 32'd1;
        frame_total            = '0;
        if (open_kind != KIND_CHAT) begin
          // Fixed-size types are checked at the type byte
          need = (open_kind == KIND_MOVE) ? LEN_MOVE : LEN_ACTION;
          if (need > max_bytes) begin
            r.marks.aborted = 1'b1;
            link_closed     = 1'b1;
            drop_frame();
          end else begin
            frame_total = need;
          end
        end
      end else begin
        r.marks.skipped = 1'b1;
      end
    end else begin
      r.frame_kind   = open_kind;
      pos            = bytes_in_frame;
      bytes_in_frame = pos + 32'd1;
      if (open_kind == KIND_CHAT && pos < CHAT_HEADER) begin
        // Collect the little-endian chat length
        if (pos >= CHAT_LEN_POS)
          frame_total = frame_total | ({24'h0, b} << (8 * (pos - CHAT_LEN_POS)));
        if (pos == CHAT_HEADER - 32'd1) begin
          total = {1'b0, frame_total} + {1'b0, CHAT_HEADER};
          if (total > {1'b0, max_bytes}) begin
            r.marks.aborted = 1'b1;
            link_closed     = 1'b1;
            drop_frame();
          end else begin
            frame_total = total[31:0];
            done        = (bytes_in_frame >= frame_total);
          end
        end
      end else begin
        done = (bytes_in_frame >= frame_total);
      end
      if (done) begin
        r.marks.last_of_frame = 1'b1;
        drop_frame();
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t ns: result %0d %s expected %0h, got %0h",
               $time, result_index, name, want, got);
    end
  endfunction

  // Track config, compare results, then predict newly accepted bytes
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      max_bytes   = MAX_RESET;
      link_closed = 1'b0;
      drop_frame();
      marks_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        max_bytes = cfg_max;
      if (out_valid && !out_stall) begin
        got.byte_out             = byte_out;
        got.frame_kind           = kind_t'(frame_kind);
        got.marks.first_of_frame = first_of_frame;
        got.marks.last_of_frame  = last_of_frame;
        got.marks.skipped        = skipped;
        got.marks.aborted        = aborted;
        got.marks.ignored        = ignored;
        if (marks_due.size() == 0) begin
          err_count++;
          $display("%0t ns: result with no byte pending, expected none, got byte %0h",
                   $time, byte_out);
        end else begin
          want = marks_due.pop_front();
          check_field("byte_out", want.byte_out, got.byte_out);
          check_field("frame_kind", want.frame_kind, got.frame_kind);
          check_field("first_of_frame", want.marks.first_of_frame,
                      got.marks.first_of_frame);
          check_field("last_of_frame", want.marks.last_of_frame,
                      got.marks.last_of_frame);
          check_field("skipped", want.marks.skipped, got.marks.skipped);
          check_field("aborted", want.marks.aborted, got.marks.aborted);
          check_field("ignored", want.marks.ignored, got.marks.ignored);
        end
        result_index++;
      end
      if (in_valid && !in_stall)
        marks_due.push_back(predict_marks(data_byte));
    end
    errors  <= err_count;
    pending <= marks_due.size();
  end

endmodule

`default_nettype wire

FILE: bench/tb_typed_message_deframer.sv
// ----------------------------------------------------------------------------
// tb_typed_message_deframer
// Drives byte streams of typed messages into the deframer and gives the
// verdict. Whole messages with random content and stray bytes between them
// go through phases of idling and stalling and several length limits, one of
// them changed inside a chat header. A receiver hold-off fills the block.
// The run ends with an oversize frame that closes the link, then bytes that
// must come back ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_typed_message_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import tmd_pkg::*;

  localparam int HOLD_CYCLES = 200;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_max = 32'h0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  byte_out;
  logic [1:0]  frame_kind;
  logic        first_of_frame;
  logic        last_of_frame;
  logic        skipped;
  logic        aborted;
  logic        ignored;
  logic        cfg_ready;

  int          fail_count;
  int          due_count;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          bytes_sent = 0;
  logic [31:0] cur_max = MAX_RESET;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;

  typed_message_deframer u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_byte         (data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .byte_out          (byte_out),
    .frame_kind        (frame_kind),
    .first_of_frame    (first_of_frame),
    .last_of_frame     (last_of_frame),
    .skipped           (skipped),
    .aborted           (aborted),
    .ignored           (ignored),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .max_message_bytes (cfg_max)
  );

  deframer_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .byte_out       (byte_out),
    .frame_kind     (frame_kind),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame),
    .skipped        (skipped),
    .aborted        (aborted),
    .ignored        (ignored),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max        (cfg_max),
    .errors         (fail_count),
    .pending        (due_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stall the output at random, or hold it off for one long stretch
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one byte, idling first at random, and wait for its transaction
  task automatic send_byte(input logic [7:0] b);
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  // Send a chat length, low byte first
  task automatic send_len(input logic [31:0] len);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
  endtask

  // Wait until every predicted result is back and the block is quiet
  task automatic settle();
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_max(input logic [31:0] v);
    in_valid <= 1'b0;
    settle();
    cfg_valid <= 1'b1;
    cfg_max   <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_max = v;
  endtask

  // Send one whole message that fits the limit, or a stray byte
  task automatic send_message(input logic [31:0] limit);
    int unsigned pick;
    int unsigned top_len;
    logic [31:0] len;
    logic [7:0]  t;
    pick = $urandom_range(9);
    if (pick < 2 || limit < LEN_ACTION) begin
      t = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(4, 255));
      send_byte(t);
    end else if (pick < 5 && LEN_MOVE <= limit) begin
      send_byte(8'(KIND_MOVE));
      send_random(13);
    end else if (pick < 7 || limit < CHAT_HEADER) begin
      send_byte(8'(KIND_ACTION));
      send_random(5);
    end else begin
      top_len = (limit - CHAT_HEADER > 40) ? 40 : limit - CHAT_HEADER;
      len = $urandom_range(top_len);
      send_byte(8'(KIND_CHAT));
      send_random(4);
      send_len(len);
      send_random(len);
    end
  endtask

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed: stray bytes at both ends, then each message type
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'(KIND_ACTION));
    send_random(5);
    send_byte(8'(KIND_MOVE));
    send_random(13);
    send_byte(8'(KIND_CHAT));
    send_random(4);
    send_len(32'd0);

    // Reset limit, no idling
    while (bytes_sent < 230) send_message(cur_max);

    // Widest limit, sender idles
    write_max(32'hFFFF_FFFF);
    send_idle_pct = 82;
    while (bytes_sent < 380) send_message(cur_max);

    // Tighten the limit inside a chat header; the frame fits it exactly
    send_byte(8'(KIND_CHAT));
    send_random(4);
    write_max(LEN_MOVE);
    send_idle_pct  = 0;
    recv_stall_pct = 82;
    send_len(32'd5);
    send_random(5);
    while (bytes_sent < 540) send_message(cur_max);

    // Random small limit, both sides idle now and then
    write_max(32'($urandom_range(9, 60)));
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    while (bytes_sent < 700) send_message(cur_max);

    // Hold off the receiver while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    while (bytes_sent < 800) send_message(cur_max);

    // Close the link with one oversize frame
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    case ($urandom_range(2))
      0: begin
        write_max(32'd1);
        send_byte(8'h00);
        send_byte(8'($urandom_range(4, 255)));
        send_byte($urandom_range(1) ? 8'(KIND_MOVE) : 8'(KIND_ACTION));
      end
      1: begin
        // Chat that would end on its last header byte
        send_byte(8'(KIND_CHAT));
        send_random(4);
        write_max(32'd1);
        send_len(32'd0);
      end
      default: begin
        // Chat length whose total does not fit in 32 bits
        write_max(32'hFFFF_FFFF);
        send_byte(8'(KIND_CHAT));
        send_random(4);
        send_len(32'hFFFF_FFFF - 32'($urandom_range(8)));
      end
    endcase
    send_byte(8'(KIND_CHAT));
    send_random(20);

    // Drain and report
    in_valid <= 1'b0;
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/tmd_pkg.sv
src/tmd_core.sv
src/typed_message_deframer.sv
bench/deframer_checker.sv
bench/tb_typed_message_deframer.sv
